// File: rtl/core/multichannel_biquad_iir_cascade_assert.svh
// assertion macros for the checker
`ifndef MULTICHANNEL_BIQUAD_IIR_CASCADE_ASSERT_SVH
`define MULTICHANNEL_BIQUAD_IIR_CASCADE_ASSERT_SVH

// same-cycle implication
`define MBQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MBQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/mbq_pkg.sv
package mbq_pkg;

  localparam int COEF_W   = 24;
  localparam int DATA_W   = 40;
  localparam int PROD_W   = COEF_W + DATA_W;
  localparam int ACC_W    = PROD_W + 3;
  localparam int COEF_FRAC = 20;
  localparam int GAIN_SHIFT = 4;
  localparam int OUT_SHIFT  = 16;
  localparam int COEFS_PER_STAGE = 6;
  localparam int NUM_SLOTS = 5;

  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_COEF   = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  localparam logic REG_STAGES = 1'b0;
  localparam logic REG_GAIN   = 1'b1;

  localparam logic [2:0] POS_B0 = 3'd0;
  localparam logic [2:0] POS_B1 = 3'd1;
  localparam logic [2:0] POS_B2 = 3'd2;
  localparam logic [2:0] POS_A1 = 3'd4;
  localparam logic [2:0] POS_A2 = 3'd5;

  localparam int SLOT_B0 = 0;
  localparam int SLOT_B1 = 1;
  localparam int SLOT_B2 = 2;
  localparam int SLOT_A1 = 3;
  localparam int SLOT_A2 = 4;

  localparam logic [2:0] SLOT_POS [NUM_SLOTS] = '{POS_B0, POS_B1, POS_B2, POS_A1, POS_A2};

  localparam logic signed [ACC_W-1:0] DATA_MAX =
    {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] DATA_MIN =
    {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_PRE_MUL,
    OP_PRE_RND,
    OP_A1,
    OP_A2,
    OP_W_ACC,
    OP_B1,
    OP_B2,
    OP_B0,
    OP_Y_ACC,
    OP_Y_RND,
    OP_FIN
  } lane_op_e;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coef_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     clip;
  } data_sat_t;

  function automatic logic signed [ACC_W-1:0] rnd_shr(input logic signed [ACC_W-1:0] a,
                                                      input int unsigned n);
    logic signed [ACC_W-1:0] half;
    half = ACC_W'(1) <<< (n - 1);
    return (a + half) >>> n;
  endfunction

  function automatic data_sat_t sat_data(input logic signed [ACC_W-1:0] r);
    data_sat_t res;
    if (r > DATA_MAX) begin
      res.val  = DATA_MAX[DATA_W-1:0];
      res.clip = 1'b1;
    end else if (r < DATA_MIN) begin
      res.val  = DATA_MIN[DATA_W-1:0];
      res.clip = 1'b1;
    end else begin
      res.val  = r[DATA_W-1:0];
      res.clip = 1'b0;
    end
    return res;
  endfunction

endpackage

// File: rtl/core/mbq_in_if.sv
interface mbq_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic [1:0]                     req_type;
  logic [3:0]                     channel;
  logic signed [SAMPLE_WIDTH-1:0] sample_re;
  logic signed [SAMPLE_WIDTH-1:0] sample_im;
  logic [5:0]                     coeff_index;
  logic signed [23:0]             coeff_value;

  modport source (
    output valid, req_type, channel, sample_re, sample_im, coeff_index, coeff_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, channel, sample_re, sample_im, coeff_index, coeff_value,
    output ready
  );
endinterface

// File: rtl/core/mbq_out_if.sv
interface mbq_out_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic [3:0]                     out_channel;
  logic signed [SAMPLE_WIDTH-1:0] out_re;
  logic signed [SAMPLE_WIDTH-1:0] out_im;
  logic                           saturated;

  modport source (
    output valid, out_channel, out_re, out_im, saturated,
    input  ready
  );
  modport sink (
    input  valid, out_channel, out_re, out_im, saturated,
    output ready
  );
endinterface

// File: rtl/core/mbq_ram.sv
module mbq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 128
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: rtl/core/mbq_lane.sv
module mbq_lane import mbq_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk_i,
  input  lane_op_e                       op_i,
  input  coef_t                          coef_i,
  input  logic signed [COEF_W-1:0]       gain_i,
  input  logic signed [SAMPLE_WIDTH-1:0] x_i,
  input  logic signed [DATA_W-1:0]       z1_i,
  input  logic signed [DATA_W-1:0]       z2_i,
  output logic signed [DATA_W-1:0]       w_o,
  output logic signed [SAMPLE_WIDTH-1:0] y_o,
  output logic                           sat_o
);

  localparam logic signed [ACC_W-1:0] SMAX =
    {{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SMIN =
    {{(ACC_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

  logic signed [COEF_W-1:0]       mul_a;
  logic signed [DATA_W-1:0]       mul_b;
  logic signed [PROD_W-1:0]       prod;
  logic signed [PROD_W-1:0]       prod_q;
  logic signed [ACC_W-1:0]        prod_x;
  logic signed [ACC_W-1:0]        acc_q;
  logic signed [ACC_W-1:0]        v_sh;
  logic signed [ACC_W-1:0]        y_rnd;
  logic signed [DATA_W-1:0]       v_q;
  logic signed [DATA_W-1:0]       w_q;
  logic signed [SAMPLE_WIDTH-1:0] y_q;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;
  logic                           y_clip;
  logic                           sat_q;
  data_sat_t                      rs_pre;
  data_sat_t                      rs_acc;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (op_i)
      OP_PRE_MUL: begin
        mul_a = gain_i;
        mul_b = {{(DATA_W-SAMPLE_WIDTH){x_i[SAMPLE_WIDTH-1]}}, x_i};
      end
      OP_A1: begin
        mul_a = coef_i.a1;
        mul_b = z1_i;
      end
      OP_A2: begin
        mul_a = coef_i.a2;
        mul_b = z2_i;
      end
      OP_B1: begin
        mul_a = coef_i.b1;
        mul_b = z1_i;
      end
      OP_B2: begin
        mul_a = coef_i.b2;
        mul_b = z2_i;
      end
      OP_B0: begin
        mul_a = coef_i.b0;
        mul_b = w_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign prod_x = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
  assign v_sh   = {{(ACC_W-DATA_W-COEF_FRAC){v_q[DATA_W-1]}}, v_q, {COEF_FRAC{1'b0}}};
  assign rs_pre = sat_data(rnd_shr(prod_x, GAIN_SHIFT));
  assign rs_acc = sat_data(rnd_shr(acc_q, COEF_FRAC));
  assign y_rnd  = rnd_shr({{(ACC_W-DATA_W){v_q[DATA_W-1]}}, v_q}, OUT_SHIFT);

  always_comb begin
    if (y_rnd > SMAX) begin
      y_sat  = SMAX[SAMPLE_WIDTH-1:0];
      y_clip = 1'b1;
    end else if (y_rnd < SMIN) begin
      y_sat  = SMIN[SAMPLE_WIDTH-1:0];
      y_clip = 1'b1;
    end else begin
      y_sat  = y_rnd[SAMPLE_WIDTH-1:0];
      y_clip = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (op_i)
      OP_IDLE: begin
      end
      OP_PRE_MUL: begin
        prod_q <= prod;
        sat_q  <= 1'b0;
      end
      OP_PRE_RND: begin
        v_q   <= rs_pre.val;
        sat_q <= sat_q | rs_pre.clip;
      end
      OP_A1: begin
        prod_q <= prod;
        acc_q  <= v_sh;
      end
      OP_A2: begin
        prod_q <= prod;
        acc_q  <= acc_q - prod_x;
      end
      OP_W_ACC: begin
        acc_q <= acc_q - prod_x;
      end
      OP_B1: begin
        w_q    <= rs_acc.val;
        sat_q  <= sat_q | rs_acc.clip;
        prod_q <= prod;
        acc_q  <= '0;
      end
      OP_B2, OP_B0: begin
        prod_q <= prod;
        acc_q  <= acc_q + prod_x;
      end
      OP_Y_ACC: begin
        acc_q <= acc_q + prod_x;
      end
      OP_Y_RND: begin
        v_q   <= rs_acc.val;
        sat_q <= sat_q | rs_acc.clip;
      end
      OP_FIN: begin
        y_q   <= y_sat;
        sat_q <= sat_q | y_clip;
      end
    endcase
  end

  assign w_o   = w_q;
  assign y_o   = y_q;
  assign sat_o = sat_q;

endmodule

// File: rtl/core/mbq_merge.sv
module mbq_merge #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic [3:0]                     ch_i,
  input  logic signed [SAMPLE_WIDTH-1:0] re_i,
  input  logic signed [SAMPLE_WIDTH-1:0] im_i,
  input  logic                           sat_re_i,
  input  logic                           sat_im_i,
  output logic                           full_o,
  mbq_out_if.source                      out_o
);

  logic                           valid_q;
  logic [3:0]                     ch_q;
  logic signed [SAMPLE_WIDTH-1:0] re_q;
  logic signed [SAMPLE_WIDTH-1:0] im_q;
  logic                           sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ch_q  <= ch_i;
      re_q  <= re_i;
      im_q  <= im_i;
      sat_q <= sat_re_i | sat_im_i;
    end
  end

  assign full_o            = valid_q;
  assign out_o.valid       = valid_q;
  assign out_o.out_channel = ch_q;
  assign out_o.out_re      = re_q;
  assign out_o.out_im      = im_q;
  assign out_o.saturated   = sat_q;

endmodule

// File: rtl/core/multichannel_biquad_iir_cascade.sv
// multichannel cascade of direct form II biquads on complex samples
// in_i takes requests: filter a sample, write one coefficient, or clear
// all delay state; out_o returns one result per filtered sample
// registers over apb: stages in use at 0x0, input gain (q4.20) at 0x4
// real and imaginary parts run in two lanes side by side, each with one
// multiplier that takes five products per stage
// a sample request keeps in_i busy through the gain step, then per stage
// in use a delay read, five products and the w and y roundings, then the
// final rounding and the push; coefficient writes and clears keep it ready
// the push state loads the result into the output register behind out_o
// a finished result waits in the output register while the next request
// is taken; if the receiver still stalls when the next result is done,
// the block holds it and takes no request until the register frees
// reset zeroes coefficients and delay state through valid bits, sets one
// stage and unity gain; no clearing pass is needed
module multichannel_biquad_iir_cascade import mbq_pkg::*; #(
  parameter int CHANNELS     = 16,
  parameter int MAX_STAGES   = 8,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mbq_in_if.sink      in_i,
  mbq_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DEPTH = CHANNELS * MAX_STAGES;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int STW   = MAX_STAGES > 1 ? $clog2(MAX_STAGES) : 1;
  localparam int RAM_W = 2 * DATA_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRE_MUL,
    ST_PRE_RND,
    ST_RD,
    ST_A1,
    ST_A2,
    ST_WACC,
    ST_B1,
    ST_B2,
    ST_B0,
    ST_YACC,
    ST_YRND,
    ST_FIN,
    ST_PUSH
  } state_e;

  state_e                         state_q;
  logic [STW-1:0]                 stg_q;
  logic [3:0]                     ch_q;
  logic signed [SAMPLE_WIDTH-1:0] x_re_q;
  logic signed [SAMPLE_WIDTH-1:0] x_im_q;
  logic [AW-1:0]                  addr_q;
  logic                           zvld_q;
  logic [NUM_SLOTS-1:0]           cvld_q;
  logic [DEPTH-1:0]               dvalid_q;
  logic [NUM_SLOTS-1:0][MAX_STAGES-1:0] cvalid_q;
  logic [3:0]                     stages_q;
  logic signed [COEF_W-1:0]       gain_q;

  logic                           accept;
  logic                           ch_ok;
  logic [4:0]                     st5;
  logic [4:0]                     act5;
  logic [STW-1:0]                 last_stg;
  logic [12:0]                    div_q;
  logic [3:0]                     cw_stg;
  logic [5:0]                     cw_pos;
  logic [6:0]                     cw_lim;
  logic                           cw_en;
  logic [NUM_SLOTS-1:0]           cw_we;
  logic [AW-1:0]                  rd_addr;
  logic                           rd_en;
  logic                           d_we;
  logic                           push;
  logic                           full;
  lane_op_e                       op;
  coef_t                          coef;
  logic [COEF_W-1:0]              crd [NUM_SLOTS];
  logic [RAM_W-1:0]               rd_re;
  logic [RAM_W-1:0]               rd_im;
  logic signed [DATA_W-1:0]       z1_re;
  logic signed [DATA_W-1:0]       z2_re;
  logic signed [DATA_W-1:0]       z1_im;
  logic signed [DATA_W-1:0]       z2_im;
  logic signed [DATA_W-1:0]       w_re;
  logic signed [DATA_W-1:0]       w_im;
  logic signed [SAMPLE_WIDTH-1:0] y_re;
  logic signed [SAMPLE_WIDTH-1:0] y_im;
  logic                           sat_re;
  logic                           sat_im;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stages_q <= 4'd1;
      gain_q   <= 24'h100000;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_GAIN) begin
        gain_q <= pwdata[COEF_W-1:0];
      end else begin
        stages_q <= pwdata[3:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_GAIN) begin
      prdata = {{(32-COEF_W){gain_q[COEF_W-1]}}, gain_q};
    end else begin
      prdata = {28'd0, stages_q};
    end
  end

  assign pready = 1'b1;

  // active stage count
  assign st5 = {1'b0, stages_q};
  always_comb begin
    if (st5 == 5'd0) begin
      act5 = 5'd1;
    end else if (st5 > 5'(MAX_STAGES)) begin
      act5 = 5'(MAX_STAGES);
    end else begin
      act5 = st5;
    end
  end
  assign last_stg = STW'(act5 - 5'd1);

  // request decode
  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign ch_ok      = 32'(in_i.channel) < CHANNELS;

  // index / 6 by reciprocal, exact below 128
  assign div_q  = {7'd0, in_i.coeff_index} * 13'd43;
  assign cw_stg = div_q[11:8];
  assign cw_pos = in_i.coeff_index - ({1'b0, cw_stg, 1'b0} + {cw_stg, 2'b00});
  assign cw_lim = 7'({2'b00, act5} * 7'(COEFS_PER_STAGE));
  assign cw_en  = accept && (in_i.req_type == REQ_COEF) && ({1'b0, in_i.coeff_index} < cw_lim);

  always_comb begin
    for (int k = 0; k < NUM_SLOTS; k++) begin
      cw_we[k] = cw_en && (cw_pos == {3'b000, SLOT_POS[k]});
    end
  end

  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_coef
    mbq_ram #(
      .WIDTH(COEF_W),
      .DEPTH(MAX_STAGES)
    ) u_coef_ram (
      .clk_i  (clk_i),
      .we_i   (cw_we[k]),
      .waddr_i(cw_stg[STW-1:0]),
      .wdata_i(in_i.coeff_value),
      .re_i   (rd_en),
      .raddr_i(stg_q),
      .rdata_o(crd[k])
    );
  end

  assign coef.b0 = cvld_q[SLOT_B0] ? crd[SLOT_B0] : '0;
  assign coef.b1 = cvld_q[SLOT_B1] ? crd[SLOT_B1] : '0;
  assign coef.b2 = cvld_q[SLOT_B2] ? crd[SLOT_B2] : '0;
  assign coef.a1 = cvld_q[SLOT_A1] ? crd[SLOT_A1] : '0;
  assign coef.a2 = cvld_q[SLOT_A2] ? crd[SLOT_A2] : '0;

  // delay state, row = stage * CHANNELS + channel, data {z1, z2}
  assign rd_en   = (state_q == ST_RD);
  assign rd_addr = AW'(32'(stg_q) * CHANNELS + 32'(ch_q));
  assign d_we    = (state_q == ST_B0);

  mbq_ram #(
    .WIDTH(RAM_W),
    .DEPTH(DEPTH)
  ) u_delay_re (
    .clk_i  (clk_i),
    .we_i   (d_we),
    .waddr_i(addr_q),
    .wdata_i({w_re, z1_re}),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_re)
  );

  mbq_ram #(
    .WIDTH(RAM_W),
    .DEPTH(DEPTH)
  ) u_delay_im (
    .clk_i  (clk_i),
    .we_i   (d_we),
    .waddr_i(addr_q),
    .wdata_i({w_im, z1_im}),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_im)
  );

  assign z1_re = zvld_q ? rd_re[RAM_W-1:DATA_W] : '0;
  assign z2_re = zvld_q ? rd_re[DATA_W-1:0]     : '0;
  assign z1_im = zvld_q ? rd_im[RAM_W-1:DATA_W] : '0;
  assign z2_im = zvld_q ? rd_im[DATA_W-1:0]     : '0;

  always_comb begin
    unique case (state_q)
      ST_PRE_MUL: op = OP_PRE_MUL;
      ST_PRE_RND: op = OP_PRE_RND;
      ST_A1:      op = OP_A1;
      ST_A2:      op = OP_A2;
      ST_WACC:    op = OP_W_ACC;
      ST_B1:      op = OP_B1;
      ST_B2:      op = OP_B2;
      ST_B0:      op = OP_B0;
      ST_YACC:    op = OP_Y_ACC;
      ST_YRND:    op = OP_Y_RND;
      ST_FIN:     op = OP_FIN;
      default:    op = OP_IDLE;
    endcase
  end

  mbq_lane #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_lane_re (
    .clk_i (clk_i),
    .op_i  (op),
    .coef_i(coef),
    .gain_i(gain_q),
    .x_i   (x_re_q),
    .z1_i  (z1_re),
    .z2_i  (z2_re),
    .w_o   (w_re),
    .y_o   (y_re),
    .sat_o (sat_re)
  );

  mbq_lane #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_lane_im (
    .clk_i (clk_i),
    .op_i  (op),
    .coef_i(coef),
    .gain_i(gain_q),
    .x_i   (x_im_q),
    .z1_i  (z1_im),
    .z2_i  (z2_im),
    .w_o   (w_im),
    .y_o   (y_im),
    .sat_o (sat_im)
  );

  assign push = (state_q == ST_PUSH) && !full;

  mbq_merge #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ch_i    (ch_q),
    .re_i    (y_re),
    .im_i    (y_im),
    .sat_re_i(sat_re),
    .sat_im_i(sat_im),
    .full_o  (full),
    .out_o   (out_o)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      stg_q    <= '0;
      ch_q     <= '0;
      x_re_q   <= '0;
      x_im_q   <= '0;
      addr_q   <= '0;
      zvld_q   <= 1'b0;
      cvld_q   <= '0;
      dvalid_q <= '0;
      cvalid_q <= '0;
    end else begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
        if (cw_we[k]) begin
          cvalid_q[k][cw_stg[STW-1:0]] <= 1'b1;
        end
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (in_i.req_type == REQ_SAMPLE && ch_ok) begin
              ch_q    <= in_i.channel;
              x_re_q  <= in_i.sample_re;
              x_im_q  <= in_i.sample_im;
              stg_q   <= '0;
              state_q <= ST_PRE_MUL;
            end else if (in_i.req_type == REQ_CLEAR) begin
              dvalid_q <= '0;
            end
          end
        end
        ST_PRE_MUL: state_q <= ST_PRE_RND;
        ST_PRE_RND: state_q <= ST_RD;
        ST_RD: begin
          addr_q <= rd_addr;
          zvld_q <= dvalid_q[rd_addr];
          for (int k = 0; k < NUM_SLOTS; k++) begin
            cvld_q[k] <= cvalid_q[k][stg_q];
          end
          state_q <= ST_A1;
        end
        ST_A1:   state_q <= ST_A2;
        ST_A2:   state_q <= ST_WACC;
        ST_WACC: state_q <= ST_B1;
        ST_B1:   state_q <= ST_B2;
        ST_B2:   state_q <= ST_B0;
        ST_B0: begin
          dvalid_q[addr_q] <= 1'b1;
          state_q          <= ST_YACC;
        end
        ST_YACC: state_q <= ST_YRND;
        ST_YRND: begin
          if (stg_q == last_stg) begin
            state_q <= ST_FIN;
          end else begin
            stg_q   <= stg_q + 1'b1;
            state_q <= ST_RD;
          end
        end
        ST_FIN: state_q <= ST_PUSH;
        ST_PUSH: begin
          if (!full) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/mbq_checker.sv
`include "multichannel_biquad_iir_cascade_assert.svh"

module mbq_checker import mbq_pkg::*; #(
  parameter int CHANNELS     = 16,
  parameter int SAMPLE_WIDTH = 16
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic [1:0]              in_req_i,
  input logic [3:0]              in_channel_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic [3:0]              out_channel_i,
  input logic [SAMPLE_WIDTH-1:0] out_re_i,
  input logic [SAMPLE_WIDTH-1:0] out_im_i,
  input logic                    out_sat_i
);

  `MBQ_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")

  `MBQ_ASSERT_NEXT(a_out_stable, out_valid_i && !out_ready_i, $stable(out_channel_i) && $stable(out_re_i) && $stable(out_im_i) && $stable(out_sat_i), "result changed while stalled")

  `MBQ_ASSERT_NEXT(a_busy_after_sample, in_valid_i && in_ready_i && in_req_i == REQ_SAMPLE && 32'(in_channel_i) < CHANNELS, !in_ready_i, "request taken while filtering")

  `MBQ_ASSERT_NOW(a_result_from_busy, $rose(out_valid_i), !$past(in_ready_i), "result without a filtered sample")

endmodule

bind multichannel_biquad_iir_cascade mbq_checker #(
  .CHANNELS    (CHANNELS),
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_mbq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_req_i     (in_i.req_type),
  .in_channel_i (in_i.channel),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_channel_i(out_o.out_channel),
  .out_re_i     (out_o.out_re),
  .out_im_i     (out_o.out_im),
  .out_sat_i    (out_o.saturated)
);

// File: tb/sv/multichannel_biquad_iir_cascade_test.sv
module multichannel_biquad_iir_cascade_test;
  import mbq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHANNELS = 16;
  localparam int MAX_STAGES = 8;
  localparam int SAMPLE_WIDTH = 16;
  localparam int LIMIT = 3000000;
  localparam int SETTLE = 120;
  localparam longint S40_MAX = 64'sd549755813887;
  localparam longint S40_MIN = -64'sd549755813888;
  localparam longint S64_MAX = 64'sh7fffffffffffffff;
  localparam longint S64_MIN = 64'sh8000000000000000;

  typedef struct {
    logic [1:0]         kind;
    logic [3:0]         ch;
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic [5:0]         idx;
    logic signed [23:0] val;
  } request_t;

  typedef struct {
    logic [3:0]         ch;
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               sat;
  } filtered_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mbq_in_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) in_if ();
  mbq_out_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) out_if ();

  multichannel_biquad_iir_cascade #(
    .CHANNELS    (CHANNELS),
    .MAX_STAGES  (MAX_STAGES),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // filter model state
  longint    delay_one [MAX_STAGES][CHANNELS][2];
  longint    delay_two [MAX_STAGES][CHANNELS][2];
  longint    coef_q20 [COEFS_PER_STAGE*MAX_STAGES];
  logic [3:0] stage_count;
  longint    gain_q20;

  filtered_t expected_results [$];
  int        mismatches;
  int        cycles;
  int        send_idle;
  int        recv_idle;
  int        hold_left;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("multichannel_biquad_iir_cascade_test: done, errors");
      $finish;
    end
  end

  function automatic longint sat_sum(longint a, longint b);
    longint s;
    s = a + b;
    if (a > 0 && b > 0 && s < 0) return S64_MAX;
    if (a < 0 && b < 0 && s >= 0) return S64_MIN;
    return s;
  endfunction

  function automatic longint round_clip(longint acc, int n, longint lo, longint hi,
                                        inout bit clip);
    longint r;
    r = sat_sum(acc, longint'(1) << (n - 1)) >>> n;
    if (r > hi) begin
      clip = 1'b1;
      return hi;
    end
    if (r < lo) begin
      clip = 1'b1;
      return lo;
    end
    return r;
  endfunction

  function automatic int active_stages();
    if (stage_count == 0) return 1;
    if (stage_count > MAX_STAGES) return MAX_STAGES;
    return int'(stage_count);
  endfunction

  function automatic logic signed [15:0] filter_part(longint x, int ch, int part,
                                                     inout bit clip);
    longint v, acc, w, y, z1, z2;
    int     base;
    v = round_clip(gain_q20 * x, GAIN_SHIFT, S40_MIN, S40_MAX, clip);
    for (int s = 0; s < active_stages(); s++) begin
      base = s * COEFS_PER_STAGE;
      z1 = delay_one[s][ch][part];
      z2 = delay_two[s][ch][part];
      acc = v * (longint'(1) << COEF_FRAC);
      acc = sat_sum(acc, -(coef_q20[base+POS_A1] * z1));
      acc = sat_sum(acc, -(coef_q20[base+POS_A2] * z2));
      w = round_clip(acc, COEF_FRAC, S40_MIN, S40_MAX, clip);
      acc = sat_sum(sat_sum(coef_q20[base+POS_B0] * w, coef_q20[base+POS_B1] * z1),
                    coef_q20[base+POS_B2] * z2);
      y = round_clip(acc, COEF_FRAC, S40_MIN, S40_MAX, clip);
      delay_two[s][ch][part] = z1;
      delay_one[s][ch][part] = w;
      v = y;
    end
    return 16'(round_clip(v, OUT_SHIFT, -32768, 32767, clip));
  endfunction

  function automatic void predict_request(request_t r);
    filtered_t f;
    bit        clip;
    case (r.kind)
      REQ_SAMPLE: begin
        clip = 1'b0;
        f.ch = r.ch;
        f.re = filter_part(longint'(r.re), int'(r.ch), 0, clip);
        f.im = filter_part(longint'(r.im), int'(r.ch), 1, clip);
        f.sat = clip;
        expected_results.push_back(f);
      end
      REQ_COEF: begin
        if (int'(r.idx) < COEFS_PER_STAGE * active_stages())
          coef_q20[r.idx] = longint'(r.val);
      end
      REQ_CLEAR: begin
        foreach (delay_one[s, c, p]) begin
          delay_one[s][c][p] = 0;
          delay_two[s][c][p] = 0;
        end
      end
      default: ;
    endcase
  endfunction

  // result check
  always @(posedge clk_i) begin
    filtered_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result on channel %0d", out_if.out_channel);
        mismatches++;
      end else begin
        e = expected_results.pop_front();
        if (out_if.out_channel !== e.ch) begin
          $error("out_channel: expected %0d, got %0d", e.ch, out_if.out_channel);
          mismatches++;
        end
        if (out_if.out_re !== e.re) begin
          $error("out_re: expected %0d, got %0d", e.re, out_if.out_re);
          mismatches++;
        end
        if (out_if.out_im !== e.im) begin
          $error("out_im: expected %0d, got %0d", e.im, out_if.out_im);
          mismatches++;
        end
        if (out_if.saturated !== e.sat) begin
          $error("saturated: expected %0d, got %0d", e.sat, out_if.saturated);
          mismatches++;
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_request(request_t r);
    while ($urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.req_type <= r.kind;
    in_if.channel <= r.ch;
    in_if.sample_re <= r.re;
    in_if.sample_im <= r.im;
    in_if.coeff_index <= r.idx;
    in_if.coeff_value <= r.val;
    in_if.valid <= 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    predict_request(r);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_STAGES) stage_count = data[3:0];
    else gain_q20 = longint'($signed(data[23:0]));
  endtask

  function automatic request_t sample_req(logic [3:0] ch, logic signed [15:0] re,
                                          logic signed [15:0] im);
    request_t r;
    r = '{kind: REQ_SAMPLE, ch: ch, re: re, im: im, idx: '0, val: '0};
    return r;
  endfunction

  function automatic request_t coef_req(logic [5:0] idx, logic signed [23:0] val);
    request_t r;
    r = '{kind: REQ_COEF, ch: '0, re: '0, im: '0, idx: idx, val: val};
    return r;
  endfunction

  function automatic logic signed [23:0] rand_coef(logic [5:0] idx);
    if ($urandom_range(7) == 0) return 24'($urandom);
    case (idx % COEFS_PER_STAGE)
      POS_A1: return 24'($urandom_range(0, 3145728)) - 24'sd1572864;
      POS_A2: return 24'($urandom_range(0, 1468006)) - 24'sd734003;
      default: return 24'($urandom_range(0, 1048576)) - 24'sd524288;
    endcase
  endfunction

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 64)) - 16'sd32;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic request_t rand_req();
    request_t r;
    int       pick;
    pick = $urandom_range(99);
    r = sample_req(4'($urandom), rand_sample(), rand_sample());
    r.idx = 6'($urandom);
    r.val = rand_coef(r.idx);
    if (pick < 8) r.kind = REQ_COEF;
    else if (pick < 10) r.kind = REQ_CLEAR;
    else if (pick < 12) r.kind = 2'd3;
    return r;
  endfunction

  task automatic load_filter();
    for (int i = 0; i < COEFS_PER_STAGE * MAX_STAGES; i++)
      send_request(coef_req(6'(i), rand_coef(6'(i))));
  endtask

  task automatic test_directed();
    request_t r;
    write_reg(REG_STAGES, 32'd1);
    write_reg(REG_GAIN, 32'd1048576);
    send_request(sample_req(4'd0, 16'sh7fff, 16'sh8000));
    send_request(coef_req(6'(POS_B0), 24'sd1048576));
    send_request(coef_req(6'(POS_A1), -24'sd524288));
    send_request(coef_req(6'(POS_A2), 24'sd262144));
    send_request(coef_req(6'd47, 24'sh7fffff));
    send_request(sample_req(4'd0, 16'sh7fff, 16'sh8000));
    send_request(sample_req(4'd15, 16'sh8000, 16'sh7fff));
    send_request(sample_req(4'd0, 16'sd0, -16'sd1));
    r = sample_req(4'd3, 16'sd5, 16'sd5);
    r.kind = 2'd3;
    send_request(r);
    r.kind = REQ_CLEAR;
    send_request(r);
    send_request(sample_req(4'd0, 16'sd100, -16'sd100));
    wait_idle();
    write_reg(REG_GAIN, 32'h007fffff);
    send_request(sample_req(4'd1, 16'sh8000, 16'sh7fff));
    wait_idle();
    write_reg(REG_GAIN, 32'h00800000);
    send_request(sample_req(4'd2, 16'sh7fff, 16'sh8000));
    send_request(coef_req(6'(POS_B1), 24'sh800000));
    send_request(sample_req(4'd2, 16'sh8000, 16'sh7fff));
    wait_idle();
    write_reg(REG_STAGES, 32'd0);
    write_reg(REG_GAIN, 32'd1048576);
    send_request(sample_req(4'd4, 16'sd1234, -16'sd4321));
    wait_idle();
    write_reg(REG_STAGES, 32'd8);
    load_filter();
    wait_idle();
    write_reg(REG_STAGES, 32'd15);
    send_request(sample_req(4'd5, 16'sh7fff, 16'sh8000));
    send_request(sample_req(4'd5, 16'sd77, 16'sd0));
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int stage_pick [6] = '{8, 1, 0, 15, 3, 5};
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 37 : (ph == 1) ? 76 : 0;
      recv_idle = (ph == 0) ? 76 : (ph == 1) ? 37 : 0;
      for (int k = 0; k < 2; k++) begin
        write_reg(REG_STAGES, 32'd8);
        write_reg(REG_GAIN, ($urandom_range(3) == 0) ? $urandom
                                                     : 32'($urandom_range(0, 2097152)));
        load_filter();
        send_request(rand_req());
        wait_idle();
        write_reg(REG_STAGES, 32'(stage_pick[ph*2+k]));
        for (int i = 0; i < 92; i++) send_request(rand_req());
        wait_idle();
      end
    end
  endtask

  task automatic test_backpressure();
    send_idle = 0;
    recv_idle = 0;
    write_reg(REG_STAGES, 32'd2);
    hold_left = 600;
    for (int i = 0; i < 40; i++) send_request(sample_req(4'($urandom), rand_sample(),
                                                         rand_sample()));
    wait_idle();
  endtask

  initial begin
    foreach (delay_one[s, c, p]) begin
      delay_one[s][c][p] = 0;
      delay_two[s][c][p] = 0;
    end
    foreach (coef_q20[i]) coef_q20[i] = 0;
    stage_count = 4'd1;
    gain_q20 = 1048576;
    mismatches = 0;
    cycles = 0;
    send_idle = 0;
    recv_idle = 0;
    hold_left = 0;
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_if.valid <= 1'b0;
    in_if.req_type <= REQ_SAMPLE;
    in_if.channel <= '0;
    in_if.sample_re <= '0;
    in_if.sample_im <= '0;
    in_if.coeff_index <= '0;
    in_if.coeff_value <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    if (mismatches == 0) begin
      $display("multichannel_biquad_iir_cascade_test: done, clean");
    end else begin
      $display("multichannel_biquad_iir_cascade_test: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/mbq_pkg.sv
rtl/core/mbq_in_if.sv
rtl/core/mbq_out_if.sv
rtl/core/mbq_ram.sv
rtl/core/mbq_lane.sv
rtl/core/mbq_merge.sv
rtl/core/multichannel_biquad_iir_cascade.sv
rtl/core/mbq_checker.sv
tb/sv/multichannel_biquad_iir_cascade_test.sv
